// ===== design/assert_macros.svh =====
// Assertion macros used by the checker file of the formatter.
// Each macro wraps one clocked concurrent assertion with a reset disable.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge while reset is released.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Next-cycle implication checked while reset is released.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/pfsf_pkg.sv =====
// Shared types, constants and helper function of the printf-style formatter.
// Used by the controller, the datapath and the top level; depends on nothing.
`timescale 1ns / 1ps

package pfsf_pkg;

    localparam int COUNT_BITS_DEF = 16;
    localparam int PTR_BITS_DEF   = 64;
    localparam int DIG_DEPTH      = 16;
    localparam int DCNT_BITS      = 5;
    localparam int OUT_COUNT_BITS = 16;

    localparam logic [31:0] RECIP10 = 32'hCCCCCCCD;

    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_DASH    = 8'h2D;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_LOW_A   = 8'h61;
    localparam logic [7:0] CH_LOW_C   = 8'h63;
    localparam logic [7:0] CH_LOW_D   = 8'h64;
    localparam logic [7:0] CH_LOW_O   = 8'h6F;
    localparam logic [7:0] CH_LOW_P   = 8'h70;
    localparam logic [7:0] CH_LOW_U   = 8'h75;
    localparam logic [7:0] CH_LOW_X   = 8'h78;

    typedef enum logic [2:0] {
        LD_DEC_NEG = 3'd0,
        LD_DEC     = 3'd1,
        LD_OCT     = 3'd2,
        LD_HEX     = 3'd3,
        LD_PTR     = 3'd4
    } ld_kind_t;

    typedef enum logic [1:0] {
        RADIX_DEC = 2'd0,
        RADIX_OCT = 2'd1,
        RADIX_HEX = 2'd2
    } radix_t;

    typedef enum logic [2:0] {
        SEL_FMT   = 3'd0,
        SEL_ARG   = 3'd1,
        SEL_DASH  = 3'd2,
        SEL_ZERO  = 3'd3,
        SEL_X     = 3'd4,
        SEL_DIGIT = 3'd5,
        SEL_END   = 3'd6
    } emit_sel_t;

    typedef struct packed {
        logic      capture;
        logic      load;
        ld_kind_t  ld_kind;
        logic      mul_step;
        logic      conv_step;
        logic      emit;
        emit_sel_t emit_sel;
        logic      emit_last;
    } cmd_t;

    typedef struct packed {
        logic [7:0] fmt_char;
        logic       arg_neg;
        logic       out_free;
        logic       conv_last;
        logic       dig_last;
    } sts_t;

    function automatic logic [7:0] hex_ascii(input logic [3:0] dig);
        logic [7:0] res;
        if (dig < 4'd10)
        begin
            res = CH_ZERO + {4'd0, dig};
        end
        else
        begin
            res = CH_LOW_A + {4'd0, dig - 4'd10};
        end
        return res;
    endfunction

endpackage

// ===== design/pfsf_dpath.sv =====
// Datapath of the formatter: input capture, digit extraction, digit store,
// character counter and the output register. Depends on pfsf_pkg.
`timescale 1ns / 1ps

module pfsf_dpath #(
    parameter int COUNT_BITS = pfsf_pkg::COUNT_BITS_DEF,
    parameter int PTR_BITS   = pfsf_pkg::PTR_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [71:0]         s_tdata,
    input  pfsf_pkg::cmd_t      cmd,
    output pfsf_pkg::sts_t      sts,
    input  logic                m_tready,
    output logic                m_tvalid,
    output logic [23:0]         m_tdata,
    output logic [1:0]          m_tuser,
    output logic                m_tlast
);
    import pfsf_pkg::*;

    localparam int WORK_BITS = (PTR_BITS > 32) ? PTR_BITS : 32;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    logic [7:0]              fmt_reg;
    logic [WORK_BITS-1:0]    arg_reg;
    logic [WORK_BITS-1:0]    work_reg;
    logic [WORK_BITS-1:0]    work_next;
    logic [63:0]             prod_reg;
    logic [63:0]             prod_next;
    logic [3:0]              digit_store [DIG_DEPTH];
    logic [DCNT_BITS-1:0]    dcnt_reg;
    logic [DCNT_BITS-1:0]    dcnt_m1;
    radix_t                  radix_reg;
    logic [COUNT_BITS-1:0]   counter_reg;
    logic [COUNT_BITS-1:0]   counter_next;

    logic                    out_valid_reg;
    logic [7:0]              out_char_reg;
    logic                    out_cv_reg;
    logic                    out_end_reg;
    logic [15:0]             out_count_reg;
    logic                    out_last_reg;

    logic [31:0]             low32;
    logic [28:0]             quot;
    logic [31:0]             quot32;
    logic [31:0]             rem32;
    logic [3:0]              new_dig;
    logic [WORK_BITS-1:0]    work_shift;
    logic [7:0]              emit_char;
    logic [31:0]             count_ext;

    assign low32     = arg_reg[31:0];
    assign quot      = prod_reg[63:35];
    assign quot32    = 32'(quot);
    assign rem32     = work_reg[31:0] - (quot32 << 3) - (quot32 << 1);
    assign prod_next = 64'(work_reg[31:0]) * 64'(RECIP10);
    assign dcnt_m1   = dcnt_reg - DCNT_BITS'(1);

    always_comb
    begin
        case (radix_reg)
            RADIX_DEC:
            begin
                new_dig    = rem32[3:0];
                work_shift = WORK_BITS'(quot);
            end
            RADIX_OCT:
            begin
                new_dig    = {1'b0, work_reg[2:0]};
                work_shift = work_reg >> 3;
            end
            default:
            begin
                new_dig    = work_reg[3:0];
                work_shift = work_reg >> 4;
            end
        endcase
    end

    always_comb
    begin
        case (cmd.ld_kind)
            LD_DEC_NEG: work_next = WORK_BITS'((~low32) + 32'd1);
            LD_PTR:     work_next = WORK_BITS'(arg_reg[PTR_BITS-1:0]);
            default:    work_next = WORK_BITS'(low32);
        endcase
    end

    always_comb
    begin
        case (cmd.emit_sel)
            SEL_FMT:   emit_char = fmt_reg;
            SEL_ARG:   emit_char = arg_reg[7:0];
            SEL_DASH:  emit_char = CH_DASH;
            SEL_ZERO:  emit_char = CH_ZERO;
            SEL_X:     emit_char = CH_LOW_X;
            default:   emit_char = CH_NUL;
        endcase
    end

    always_comb
    begin
        if (counter_reg != COUNT_MAX)
        begin
            counter_next = counter_reg + COUNT_BITS'(1);
        end
        else
        begin
            counter_next = counter_reg;
        end
    end

    assign count_ext = (cmd.emit_sel == SEL_END) ? 32'(counter_reg) : 32'(counter_next);

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            fmt_reg <= s_tdata[7:0];
            arg_reg <= s_tdata[WORK_BITS+7:8];
        end
        if (cmd.mul_step)
        begin
            prod_reg <= prod_next;
        end
        if (cmd.load)
        begin
            work_reg  <= work_next;
            radix_reg <= (cmd.ld_kind == LD_OCT) ? RADIX_OCT :
                         ((cmd.ld_kind == LD_HEX || cmd.ld_kind == LD_PTR) ? RADIX_HEX
                                                                           : RADIX_DEC);
        end
        else if (cmd.conv_step)
        begin
            work_reg <= work_shift;
        end
        if (cmd.conv_step)
        begin
            digit_store[dcnt_reg[3:0]] <= new_dig;
        end
        if (cmd.emit)
        begin
            out_char_reg  <= (cmd.emit_sel == SEL_DIGIT) ?
                             hex_ascii(digit_store[dcnt_m1[3:0]]) : emit_char;
            out_cv_reg    <= (cmd.emit_sel != SEL_END);
            out_end_reg   <= (cmd.emit_sel == SEL_END);
            out_count_reg <= count_ext[OUT_COUNT_BITS-1:0];
            out_last_reg  <= cmd.emit_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dcnt_reg      <= '0;
            counter_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                dcnt_reg <= '0;
            end
            else if (cmd.conv_step)
            begin
                dcnt_reg <= dcnt_reg + DCNT_BITS'(1);
            end
            else if (cmd.emit && cmd.emit_sel == SEL_DIGIT)
            begin
                dcnt_reg <= dcnt_m1;
            end

            if (cmd.emit)
            begin
                counter_reg <= (cmd.emit_sel == SEL_END) ? '0 : counter_next;
            end

            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign sts.fmt_char  = fmt_reg;
    assign sts.arg_neg   = arg_reg[31];
    assign sts.out_free  = !out_valid_reg || m_tready;
    assign sts.conv_last = (work_shift == '0) || (dcnt_reg == DCNT_BITS'(DIG_DEPTH - 1));
    assign sts.dig_last  = (dcnt_reg == DCNT_BITS'(1));

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_count_reg, out_char_reg};
    assign m_tuser  = {out_end_reg, out_cv_reg};
    assign m_tlast  = out_last_reg;

endmodule

// ===== design/pfsf_ctrl.sv =====
// Controller of the formatter: decodes each format byte, keeps the pending
// percent flag and sequences the datapath. Depends on pfsf_pkg.
`timescale 1ns / 1ps

module pfsf_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  pfsf_pkg::sts_t sts,
    output pfsf_pkg::cmd_t cmd
);
    import pfsf_pkg::*;

    typedef enum logic [11:0] {
        ST_IDLE   = 12'b0000_0000_0001,
        ST_DECODE = 12'b0000_0000_0010,
        ST_ECHO   = 12'b0000_0000_0100,
        ST_CHAR   = 12'b0000_0000_1000,
        ST_END    = 12'b0000_0001_0000,
        ST_SIGN   = 12'b0000_0010_0000,
        ST_PFX0   = 12'b0000_0100_0000,
        ST_PFX1   = 12'b0000_1000_0000,
        ST_MUL    = 12'b0001_0000_0000,
        ST_DIV    = 12'b0010_0000_0000,
        ST_SHIFT  = 12'b0100_0000_0000,
        ST_EMIT   = 12'b1000_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   pending_reg;
    logic   pending_next;

    always_comb
    begin
        state_next   = state_reg;
        pending_next = pending_reg;
        cmd          = '0;
        cmd.ld_kind  = LD_DEC;
        cmd.emit_sel = SEL_FMT;
        s_tready     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                if (sts.fmt_char == CH_NUL)
                begin
                    pending_next = 1'b0;
                    state_next   = ST_END;
                end
                else if (!pending_reg)
                begin
                    if (sts.fmt_char == CH_PERCENT)
                    begin
                        pending_next = 1'b1;
                        state_next   = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_ECHO;
                    end
                end
                else
                begin
                    pending_next = 1'b0;
                    case (sts.fmt_char)
                        CH_LOW_D:
                        begin
                            cmd.load    = 1'b1;
                            cmd.ld_kind = sts.arg_neg ? LD_DEC_NEG : LD_DEC;
                            state_next  = sts.arg_neg ? ST_SIGN : ST_MUL;
                        end
                        CH_LOW_U:
                        begin
                            cmd.load    = 1'b1;
                            cmd.ld_kind = LD_DEC;
                            state_next  = ST_MUL;
                        end
                        CH_LOW_O:
                        begin
                            cmd.load    = 1'b1;
                            cmd.ld_kind = LD_OCT;
                            state_next  = ST_SHIFT;
                        end
                        CH_LOW_X:
                        begin
                            cmd.load    = 1'b1;
                            cmd.ld_kind = LD_HEX;
                            state_next  = ST_SHIFT;
                        end
                        CH_LOW_P:
                        begin
                            cmd.load    = 1'b1;
                            cmd.ld_kind = LD_PTR;
                            state_next  = ST_PFX0;
                        end
                        CH_LOW_C:
                        begin
                            state_next = ST_CHAR;
                        end
                        default:
                        begin
                            state_next = ST_ECHO;
                        end
                    endcase
                end
            end
            ST_ECHO:
            begin
                if (sts.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_sel  = SEL_FMT;
                    cmd.emit_last = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_CHAR:
            begin
                if (sts.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_sel  = SEL_ARG;
                    cmd.emit_last = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_END:
            begin
                if (sts.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_sel  = SEL_END;
                    cmd.emit_last = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_SIGN:
            begin
                if (sts.out_free)
                begin
                    cmd.emit     = 1'b1;
                    cmd.emit_sel = SEL_DASH;
                    state_next   = ST_MUL;
                end
            end
            ST_PFX0:
            begin
                if (sts.out_free)
                begin
                    cmd.emit     = 1'b1;
                    cmd.emit_sel = SEL_ZERO;
                    state_next   = ST_PFX1;
                end
            end
            ST_PFX1:
            begin
                if (sts.out_free)
                begin
                    cmd.emit     = 1'b1;
                    cmd.emit_sel = SEL_X;
                    state_next   = ST_SHIFT;
                end
            end
            ST_MUL:
            begin
                cmd.mul_step = 1'b1;
                state_next   = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.conv_step = 1'b1;
                state_next    = sts.conv_last ? ST_EMIT : ST_MUL;
            end
            ST_SHIFT:
            begin
                cmd.conv_step = 1'b1;
                if (sts.conv_last)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_sel  = SEL_DIGIT;
                    cmd.emit_last = sts.dig_last;
                    if (sts.dig_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            pending_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            pending_reg <= pending_next;
        end
    end

endmodule

// ===== design/printf_format_stream_formatter.sv =====
// Flow: a byte is captured in IDLE and decoded in DECODE; a plain, end, sign or prefix beat
// then goes from ECHO, END, SIGN or PFX0/PFX1 to the output register; a bare '%' only sets
// the pending flag. Hex and octal digits are extracted in SHIFT, decimal ones in alternating
// MUL and DIV steps, as each decimal digit needs a multiply and a correct step, and all leave
// from EMIT. A new byte is taken only in IDLE, after the previous byte is done.
// Reset: asynchronous, active low; clears the state machine, pending flag, count, digit index and output valid.
`timescale 1ns / 1ps

module printf_format_stream_formatter #(
    parameter int COUNT_BITS = pfsf_pkg::COUNT_BITS_DEF,
    parameter int PTR_BITS   = pfsf_pkg::PTR_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // fmt_char[7:0], arg_value[71:8]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // out_char[7:0], total_count[23:8]
    output logic [1:0]  m_tuser,   // char_valid[0], end_of_format[1]
    output logic        m_tlast
);
    import pfsf_pkg::*;

    cmd_t cmd;
    sts_t sts;

    pfsf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    pfsf_dpath #(
        .COUNT_BITS (COUNT_BITS),
        .PTR_BITS   (PTR_BITS)
    ) u_dpath (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .cmd      (cmd),
        .sts      (sts),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

// ===== design/pfsf_checker.sv =====
// Port-level checker of the formatter and its bind to the top level.
// Depends on assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pfsf_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [71:0] s_tdata,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic [1:0]  m_tuser,
    input logic        m_tlast
);

    `ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "stalled output beat changed")
    `ASSERT_CLK(a_kind_onehot, clk, rst_n, !m_tvalid || (m_tuser[0] != m_tuser[1]), "beat is neither a character nor an end report")
    `ASSERT_CLK(a_end_shape, clk, rst_n, !(m_tvalid && m_tuser[1]) || (m_tlast && m_tdata[7:0] == 8'h00), "end report beat malformed")
    `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, s_tvalid && s_tready, !s_tready, "input accepted while previous byte still decoding")

endmodule

bind printf_format_stream_formatter pfsf_checker u_pfsf_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
